// ----- rtl/pdrdf_pkg.sv -----
// Shared types and constants of the particle dead-reckoning delta filter.
package pdrdf_pkg;

    localparam int POINTS     = 65536;
    localparam int IDX_W      = $clog2(POINTS);
    localparam int FRAME_W    = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [1:0] CFG_POS_THR   = 2'd1;
    localparam logic [1:0] CFG_JP_THR    = 2'd2;

    // Bit of the status byte that carries the crushed flag.
    localparam logic [7:0] STATUS_CRUSHED = 8'b1000_0000;

    // Command codes.
    localparam logic CMD_FULL  = 1'b0;
    localparam logic CMD_DELTA = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [FRAME_W-1:0] frame;
        logic [IDX_W-1:0]   idx;
        logic [2:0][31:0]   pos;
        logic [2:0][31:0]   vel;
        logic [31:0]        jp;
        logic [7:0]         status;
    } t_item;

    typedef struct packed {
        logic [31:0] step_time;
        logic [30:0] pos_thr;
        logic [30:0] jp_thr;
        logic [61:0] pos_thr_sq;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic [2:0][31:0]   pos;
        logic [2:0][31:0]   vel;
        logic [FRAME_W-1:0] frame;
    } t_rec;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             pos_vel_refresh;
        logic             jp_refresh;
        logic             status_refresh;
        logic [7:0]       status_byte;
    } t_result;

endpackage

// ----- rtl/particle_dead_reckoning_delta_filter_core.sv -----
// Top level of the particle dead-reckoning delta filter.
//
// Usage: configuration is written through i_cfg_valid, i_cfg_index and
// i_cfg_data while the block is idle; o_cfg_ready is always high, so every
// valid cycle is a transfer. Index 0 is step_time, 1 the position threshold
// and 2 the Jp threshold; index 3 is ignored.
// A command transfer happens at a rising edge with i_start high and o_busy
// low. Each accepted particle gives exactly one result, shown for one cycle
// with o_valid high, in acceptance order.
// From transfer to result a particle passes the queue, the five execution
// stages and the output register. Particles are taken one per cycle while
// o_busy is low. A particle whose index matches one still in the five
// execution stages waits in the four-entry queue until that record has been
// written back; o_busy rises when the queue is full.
// Reset clears the queue, the pipeline and the registers; the record store
// holds whatever it held. The receiver cannot stall, so results never wait.
module particle_dead_reckoning_delta_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_cmd,
    input  logic [pdrdf_pkg::FRAME_W-1:0]  i_frame_number,
    input  logic [pdrdf_pkg::IDX_W-1:0]    i_point_index,
    input  logic signed [31:0]             i_pos_x,
    input  logic signed [31:0]             i_pos_y,
    input  logic signed [31:0]             i_pos_z,
    input  logic signed [31:0]             i_vel_x,
    input  logic signed [31:0]             i_vel_y,
    input  logic signed [31:0]             i_vel_z,
    input  logic signed [31:0]             i_jp_value,
    input  logic [6:0]                     i_partition,
    input  logic                           i_crushed,
    output logic                           o_valid,
    output logic [pdrdf_pkg::IDX_W-1:0]    o_out_index,
    output logic                           o_pos_vel_refresh,
    output logic                           o_jp_refresh,
    output logic                           o_status_refresh,
    output logic [7:0]                     o_status_byte
);
    import pdrdf_pkg::*;

    t_item   item;
    t_head   head;
    t_cfg    cfg;
    t_result result;
    logic    pop;

    // Pack the command fields and form the status byte.
    always_comb begin
        item.cmd    = i_cmd;
        item.frame  = i_frame_number;
        item.idx    = i_point_index;
        item.pos    = {i_pos_z, i_pos_y, i_pos_x};
        item.vel    = {i_vel_z, i_vel_y, i_vel_x};
        item.jp     = i_jp_value;
        item.status = {1'b0, i_partition} | (i_crushed ? STATUS_CRUSHED : 8'd0);
    end

    assign o_cfg_ready = 1'b1;

    pdrdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_start     (i_start),
        .i_item      (item),
        .i_pop       (pop),
        .o_busy      (o_busy),
        .o_head      (head),
        .o_cfg       (cfg)
    );

    pdrdf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_cfg    (cfg),
        .o_pop    (pop),
        .o_result (result)
    );

    assign o_valid           = result.valid;
    assign o_out_index       = result.idx;
    assign o_pos_vel_refresh = result.pos_vel_refresh;
    assign o_jp_refresh      = result.jp_refresh;
    assign o_status_refresh  = result.status_refresh;
    assign o_status_byte     = result.status_byte;

    // Count of accepted particles whose results are still to come.
    logic [3:0] r_outstanding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 4'(i_start && !o_busy) - 4'(o_valid);
        end
    end

    // No result without a particle that caused it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_outstanding != '0))
        else $error("result without an accepted particle");

    // The queue plus five stages plus the output register bound the backlog.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= 4'(FIFO_DEPTH + 6))
        else $error("outstanding count beyond pipeline capacity");

    // No result straight after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result right after reset");

    // A full capture accepted into an empty block reports every refresh.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_FULL && head.valid == 1'b0 && !pop &&
         r_outstanding == '0) |-> ##7 (o_valid && o_pos_vel_refresh &&
         o_jp_refresh && o_status_refresh))
        else $error("full capture did not report all refreshes");

endmodule

// ----- rtl/pdrdf_front.sv -----
// Front end: configuration registers, command acceptance and the item queue.
module pdrdf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_start,
    input  pdrdf_pkg::t_item       i_item,
    input  logic                   i_pop,
    output logic                   o_busy,
    output pdrdf_pkg::t_head       o_head,
    output pdrdf_pkg::t_cfg        o_cfg
);
    import pdrdf_pkg::*;

    logic [31:0] r_step_time;
    logic [30:0] r_pos_thr;
    logic [30:0] r_jp_thr;
    logic [61:0] r_pos_thr_sq;

    t_item              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               push, pop;

    // Configuration writes; the squared threshold is registered from the stored position threshold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_time <= '0;
            r_pos_thr   <= '0;
            r_jp_thr    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP_TIME: r_step_time <= i_cfg_data;
                CFG_POS_THR:   r_pos_thr   <= i_cfg_data[30:0];
                CFG_JP_THR:    r_jp_thr    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_thr_sq <= r_pos_thr * r_pos_thr;
    end

    assign o_cfg = '{step_time: r_step_time, pos_thr: r_pos_thr,
                     jp_thr: r_jp_thr, pos_thr_sq: r_pos_thr_sq};

    // Queue between acceptance and execution.
    assign o_busy = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
    end

    assign o_head = '{valid: (r_count != '0), item: r_fifo[r_rd_ptr]};

endmodule

// ----- rtl/pdrdf_back.sv -----
// Back end: record memories and the prediction and compare pipeline.
module pdrdf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pdrdf_pkg::t_head      i_head,
    input  pdrdf_pkg::t_cfg       i_cfg,
    output logic                  o_pop,
    output pdrdf_pkg::t_result    o_result
);
    import pdrdf_pkg::*;

    // Record memories, one per write enable group.
    t_rec        mem_rec [POINTS];
    logic [31:0] mem_jp  [POINTS];
    logic [7:0]  mem_st  [POINTS];

    t_rec        r_rd_rec;
    logic [31:0] r_rd_jp;
    logic [7:0]  r_rd_st;

    logic  r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item r_s1, r_s2, r_s3, r_s4, r_s5;
    logic  r_jr2, r_jr3, r_jr4, r_jr5;
    logic  r_sr2, r_sr3, r_sr4, r_sr5;

    logic [55:0]       r_t2;
    logic [2:0][31:0]  r_mag2;
    logic [2:0]        r_neg2, r_neg3;
    logic [2:0][31:0]  r_sp2, r_sp3;
    logic [2:0][63:0]  r_pplo3;
    logic [2:0][55:0]  r_pphi3;
    logic [2:0][59:0]  r_e4;
    logic              r_over5;
    logic [2:0][61:0]  r_sq5;

    t_result r_out;
    logic    hazard;

    // An item waits while an older item for the same particle is in flight.
    always_comb begin
        hazard = (r_v1 && r_s1.idx == i_head.item.idx) ||
                 (r_v2 && r_s2.idx == i_head.item.idx) ||
                 (r_v3 && r_s3.idx == i_head.item.idx) ||
                 (r_v4 && r_s4.idx == i_head.item.idx) ||
                 (r_v5 && r_s5.idx == i_head.item.idx);
    end

    assign o_pop = i_head.valid && !hazard;

    // Read of the stored record for the item leaving the queue.
    always_ff @(posedge i_clk) begin
        r_rd_rec <= mem_rec[i_head.item.idx];
        r_rd_jp  <= mem_jp[i_head.item.idx];
        r_rd_st  <= mem_st[i_head.item.idx];
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage one: elapsed time, velocity magnitudes, Jp and status checks.
    logic [FRAME_W-1:0] elapsed;
    logic [32:0]        jp_diff, jp_mag;
    logic [2:0][31:0]   n_mag;
    logic [2:0]         n_neg;

    always_comb begin
        elapsed = r_s1.frame - r_rd_rec.frame;
        jp_diff = {r_rd_jp[31], r_rd_jp} - {r_s1.jp[31], r_s1.jp};
        jp_mag  = jp_diff[32] ? (33'd0 - jp_diff) : jp_diff;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = r_rd_rec.vel[k][31];
            n_mag[k] = n_neg[k] ? (32'd0 - r_rd_rec.vel[k]) : r_rd_rec.vel[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1   <= i_head.item;
        r_s2   <= r_s1;
        r_t2   <= i_cfg.step_time * elapsed;
        r_mag2 <= n_mag;
        r_neg2 <= n_neg;
        r_sp2  <= r_rd_rec.pos;
        r_jr2  <= (r_s1.cmd == CMD_FULL) || (jp_mag > {2'b0, i_cfg.jp_thr});
        r_sr2  <= (r_s1.cmd == CMD_FULL) || (r_rd_st != r_s1.status);
    end

    // Stage two: partial products of the displacement.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pplo3[k] <= r_mag2[k] * r_t2[31:0];
            r_pphi3[k] <= r_mag2[k] * r_t2[55:32];
        end
        r_s3   <= r_s2;
        r_neg3 <= r_neg2;
        r_sp3  <= r_sp2;
        r_jr3  <= r_jr2;
        r_sr3  <= r_sr2;
    end

    // Stage three: prediction error per component.
    logic [2:0][56:0] disp_mag;
    logic signed [59:0] disp, spos, npos;
    logic [2:0][59:0] n_e;

    always_comb begin
        disp = '0;
        spos = '0;
        npos = '0;
        for (int k = 0; k < 3; k++) begin
            disp_mag[k] = 57'(r_pphi3[k]) + 57'(r_pplo3[k][63:32]);
            disp = r_neg3[k] ? -$signed({3'b0, disp_mag[k]}) : $signed({3'b0, disp_mag[k]});
            spos = $signed({{28{r_sp3[k][31]}}, r_sp3[k]});
            npos = $signed({{28{r_s3.pos[k][31]}}, r_s3.pos[k]});
            n_e[k] = npos - (spos + disp);
        end
    end

    always_ff @(posedge i_clk) begin
        r_e4  <= n_e;
        r_s4  <= r_s3;
        r_jr4 <= r_jr3;
        r_sr4 <= r_sr3;
    end

    // Stage four: magnitudes, threshold test and squares.
    logic [2:0][59:0] err_mag;
    logic             n_over;

    always_comb begin
        n_over = 1'b0;
        for (int k = 0; k < 3; k++) begin
            err_mag[k] = r_e4[k][59] ? (60'd0 - r_e4[k]) : r_e4[k];
            if (err_mag[k] > {29'b0, i_cfg.pos_thr}) n_over = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq5[k] <= err_mag[k][30:0] * err_mag[k][30:0];
        end
        r_over5 <= n_over;
        r_s5    <= r_s4;
        r_jr5   <= r_jr4;
        r_sr5   <= r_sr4;
    end

    // Stage five: final decision, write-back and result.
    logic [63:0] sq_sum;
    logic        pv;

    always_comb begin
        sq_sum = 64'(r_sq5[0]) + 64'(r_sq5[1]) + 64'(r_sq5[2]);
        pv     = (r_s5.cmd == CMD_FULL) || r_over5 ||
                 (sq_sum > {2'b0, i_cfg.pos_thr_sq});
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && pv) begin
            mem_rec[r_s5.idx] <= '{pos: r_s5.pos, vel: r_s5.vel, frame: r_s5.frame};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && r_jr5) begin
            mem_jp[r_s5.idx] <= r_s5.jp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v5 && r_sr5) begin
            mem_st[r_s5.idx] <= r_s5.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_v5;
        end
        r_out.idx             <= r_s5.idx;
        r_out.pos_vel_refresh <= pv;
        r_out.jp_refresh      <= r_jr5;
        r_out.status_refresh  <= r_sr5;
        r_out.status_byte     <= r_s5.status;
    end

    assign o_result = r_out;

endmodule
